FILE: src/pai_pkg.sv
package pai_pkg;

    localparam int unsigned NumWords   = 18;
    localparam int unsigned WordIdxW   = 5;
    localparam int unsigned ColorW     = 9;
    localparam int unsigned DepthZW    = 16;
    localparam int unsigned CoordW     = 12;
    localparam int unsigned DivBits    = 32;
    localparam int unsigned ShiftColor = 16;
    localparam int unsigned ShiftZ     = 14;
    localparam int unsigned ShiftW     = 10;
    localparam logic [ColorW-1:0] ColorMaxReset = 9'd255;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_PIXEL = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_DIV  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
    } t_div_cell;

    typedef struct packed {
        t_action           action;
        logic [WordIdxW-1:0] param_index;
        logic signed [31:0] param_value;
        logic [CoordW-1:0] pixel_x;
        logic [CoordW-1:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [ColorW-1:0]   red;
        logic [ColorW-1:0]   green;
        logic [ColorW-1:0]   blue;
        logic [ColorW-1:0]   alpha;
        logic [DepthZW-1:0]  depth_z;
        logic signed [31:0]  depth_w;
    } t_out_item;

endpackage

FILE: src/pai_if.sv
interface pai_if #(
    parameter type T = logic
) (
    input logic i_clk
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/pixel_attribute_interpolator.sv
// result: a pixel result is registered in the out state after eval and divide;
//   a load item writes its word at the accepting edge and gives no result
// throughput: one load item per cycle while idle with no result waiting;
//   a pixel item waits for the last to pass eval, the 4-cell divider and sink
// reset: synchronous active low; clears control and sets color_max to 255,
//   plane words are undefined until loaded
module pixel_attribute_interpolator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pai_pkg::ColorW-1:0] i_cfg_wdata,
    pai_if.sink                       in_ch,
    pai_if.source                     out_ch
);
    import pai_pkg::*;

    logic [31:0]       r_words [NumWords];
    logic [ColorW-1:0] r_cmax;
    t_state            r_state, n_state;
    logic [1:0]        r_attr;
    logic [CoordW-1:0] r_x, r_y;
    logic signed [31:0] r_acc [6];
    logic signed [31:0] r_divisor;
    logic               r_neg;
    t_out_item          r_out;
    logic               r_ovalid;
    logic               div_done;
    logic [31:0]        div_q;
    logic               in_ready;
    t_in_item           it;

    assign it       = in_ch.data;
    assign in_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign in_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmax <= ColorMaxReset;
        end else if (i_cfg_we) begin
            r_cmax <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ready && it.action == ACT_LOAD
                && it.param_index < WordIdxW'(NumWords)) begin
            r_words[it.param_index] <= it.param_value;
        end
    end

    function automatic logic signed [31:0] f_sra(logic signed [31:0] v, int unsigned n);
        return v >>> n;
    endfunction

    // two attributes (four products) per eval cycle; r_attr steps the three pairs of six
    logic signed [31:0] ev0, ev1;
    logic [31:0] px0, py0, px1, py1;
    logic [WordIdxW-1:0] base0, base1;
    always_comb begin
        base0 = {1'b0, r_attr, 2'b00} + {2'b00, r_attr, 1'b0};
        base1 = base0 + WordIdxW'(3);
        px0 = r_words[base0 + WordIdxW'(1)] * {20'd0, r_x};
        py0 = r_words[base0 + WordIdxW'(2)] * {20'd0, r_y};
        px1 = r_words[base1 + WordIdxW'(1)] * {20'd0, r_x};
        py1 = r_words[base1 + WordIdxW'(2)] * {20'd0, r_y};
        ev0 = r_words[base0] + px0 + py0;
        ev1 = r_words[base1] + px1 + py1;
    end

    logic signed [31:0] wd;
    assign wd = f_sra(r_acc[1], ShiftW);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_ch.valid && in_ready && it.action == ACT_PIXEL) n_state = ST_EVAL;
            ST_EVAL: if (r_attr == 2'd2) n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_attr  <= '0;
        end else begin
            r_state <= n_state;
            r_attr  <= (r_state == ST_EVAL) ? ((r_attr == 2'd2) ? 2'd0 : r_attr + 2'd1) : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ready) begin
            r_x <= it.pixel_x;
            r_y <= it.pixel_y;
        end
        if (r_state == ST_EVAL) begin
            r_acc[{r_attr, 1'b0}] <= ev0;
            r_acc[{r_attr, 1'b1}] <= ev1;
        end
    end

    // divisor register: magnitude of w >> 10, sign kept aside
    logic signed [31:0] ev1w;
    assign ev1w = f_sra(ev1, ShiftW);
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL && r_attr == 2'd0) begin
            r_neg     <= ev1w[31];
            r_divisor <= ev1w[31] ? -ev1w : ev1w;
        end
    end

    logic start_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_q <= 1'b0;
        end else begin
            start_q <= (r_state == ST_EVAL) && (r_attr == 2'd0);
        end
    end

    pai_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start_q),
        .i_divisor (r_divisor),
        .o_done    (div_done),
        .o_quotient(div_q)
    );

    function automatic logic [ColorW-1:0] f_color(logic signed [31:0] v,
                                                  logic [ColorW-1:0] cmax);
        logic signed [31:0] s;
        s = v >>> ShiftColor;
        if (s < 0) return '0;
        if (s > $signed({23'd0, cmax})) return cmax;
        return s[ColorW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    logic signed [31:0] zs;
    assign zs = f_sra(r_acc[0], ShiftZ);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            r_out.red   <= f_color(r_acc[2], r_cmax);
            r_out.green <= f_color(r_acc[3], r_cmax);
            r_out.blue  <= f_color(r_acc[4], r_cmax);
            r_out.alpha <= f_color(r_acc[5], r_cmax);
            r_out.depth_z <= zs[31] ? '0 : ((zs > 32'sd65535) ? 16'hFFFF : zs[15:0]);
            r_out.depth_w <= (wd == 0) ? 32'h7FFF_FFFF
                           : (r_neg ? -$signed(div_q) : $signed(div_q));
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_ovalid) else $error("result lost");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_q |-> (r_state == ST_EVAL)) else $error("divider started late");
`endif
endmodule

FILE: src/pai_div_cell.sv
module pai_div_cell (
    input  pai_pkg::t_div_cell i_prev,
    output pai_pkg::t_div_cell o_next
);
    import pai_pkg::*;

    logic [32:0]  trial;
    logic [32:0]  sh;

    always_comb begin
        sh     = {i_prev.rem, i_prev.quo[31]};
        trial  = sh - {1'b0, i_prev.dvs};
        o_next = i_prev;
        o_next.quo = {i_prev.quo[30:0], ~trial[32]};
        o_next.rem = trial[32] ? sh[31:0] : trial[31:0];
    end
endmodule

FILE: src/pai_divider.sv
module pai_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import pai_pkg::*;

    localparam int unsigned NumCells = 4;
    localparam int unsigned Rounds   = DivBits / NumCells;

    t_div_cell c [NumCells+1];
    t_div_cell r_loop;
    t_div_cell n_loop;
    logic      r_busy;
    logic [3:0] r_cnt;
    logic      run;

    assign run = r_busy;

    always_comb begin
        n_loop = c[NumCells];
        if (i_start) begin
            n_loop.rem = '0;
            n_loop.quo = 32'h4000_0000;
            n_loop.dvs = i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start || run) begin
            r_loop <= n_loop;
        end
    end

    // cells pass the partial remainder along; one bit each per round
    assign c[0] = r_loop;
    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        pai_div_cell u_cell (
            .i_prev(c[g]),
            .o_next(c[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 4'(Rounds - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 4'd1;
        end
    end

    logic r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 4'(Rounds - 1));
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_loop.quo;
endmodule
